[hw/rtl/hsfc_pkg.sv]
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants of the binary32 / binary16 format converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // Direction command carried with each item.
  typedef enum logic {
    CMD_TO_HALF   = 1'b0,
    CMD_TO_SINGLE = 1'b1
  } hsfc_cmd_e;

  // Fixed NaN patterns produced by the two directions.
  localparam logic [15:0] HalfNanCode   = 16'hFE00;
  localparam logic [31:0] SingleNanCode = 32'hFFC00000;

  // Biased exponent landmarks of binary32 seen from the binary16 range.
  localparam logic [7:0] SglExpOvf     = 8'd143;  // unbiased +16
  localparam logic [7:0] SglExpSubMin  = 8'd102;  // unbiased -25
  localparam logic [7:0] SglExpSubMax  = 8'd112;  // unbiased -15
  localparam logic [7:0] SglExpSubBase = 8'd113;  // shift = base - exponent
  localparam logic [7:0] SglExpAll1    = 8'hFF;

  // Exponent re-bias between the formats (127 - 15).
  localparam logic [7:0] ExpRebias     = 8'd112;
  // Biased single exponent of a half denormal whose leading one is bit 0.
  localparam logic [7:0] SubNormExpBase = 8'd103;

endpackage

[hw/rtl/hsfc_convert.sv]
// ----------------------------------------------------------------------------
// hsfc_convert
// Combinational core: narrows binary32 to binary16 or widens binary16 to
// binary32, selected by the command.
// ----------------------------------------------------------------------------
module hsfc_convert
  import hsfc_pkg::*;
(
  input  hsfc_cmd_e   cmd_i,
  input  logic [31:0] operand_i,
  output logic [31:0] result_o
);

  logic [31:0] half_res;
  logic [31:0] single_res;

  // Narrowing path
  always_comb begin
    logic        sgn;
    logic [7:0]  ef;
    logic [22:0] mf;
    logic [3:0]  sh;
    logic [23:0] sig;
    logic [4:0]  e5;
    logic [15:0] packed16;
    sgn      = operand_i[31];
    ef       = operand_i[30:23];
    mf       = operand_i[22:0];
    sh       = 4'(SglExpSubBase - ef);
    e5       = 5'(ef - ExpRebias);
    sig      = {1'b0, mf};
    packed16 = '0;
    half_res = '0;
    if (operand_i[30:0] == 31'h0) begin
      half_res = {16'h0, sgn, 15'h0};
    end else if (ef >= SglExpOvf) begin
      if (ef == SglExpAll1 && mf != 23'h0) begin
        half_res = {16'h0, HalfNanCode};
      end else begin
        half_res = {16'h0, sgn, 5'h1F, 10'h0};
      end
    end else if (ef < SglExpSubMin) begin
      half_res = {16'h0, sgn, 15'h0};
    end else begin
      if (ef <= SglExpSubMax) begin
        sig = {1'b1, mf} >> sh;
        e5  = 5'h0;
      end
      // Round half-up on magnitude; a carry may roll into the exponent.
      packed16 = {sgn, e5, sig[22:13]} + {15'h0, sig[12]};
      half_res = {16'h0, packed16};
    end
  end

  // Widening path
  always_comb begin
    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  lead;
    logic [22:0] frac;
    logic [7:0]  exp8;
    hs   = operand_i[15];
    he   = operand_i[14:10];
    hm   = operand_i[9:0];
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) begin
        lead = 4'(i);
      end
    end
    frac       = {hm, 13'h0};
    exp8       = {3'h0, he} + ExpRebias;
    single_res = '0;
    if (operand_i[14:0] == 15'h0) begin
      single_res = {hs, 31'h0};
    end else if (he == 5'h1F) begin
      single_res = (hm == 10'h0) ? {hs, 8'hFF, 23'h0} : SingleNanCode;
    end else if (he == 5'h0) begin
      // Move the leading one up to the hidden position and drop it.
      frac       = {hm, 13'h0} << (4'd10 - lead);
      exp8       = SubNormExpBase + {4'h0, lead};
      single_res = {hs, exp8, frac};
    end else begin
      single_res = {hs, exp8, frac};
    end
  end

  assign result_o = (cmd_i == CMD_TO_SINGLE) ? single_res : half_res;

endmodule

[hw/rtl/half_single_float_converter.sv]
// ----------------------------------------------------------------------------
// half_single_float_converter
// IEEE-754 binary32 <-> binary16 converter with valid/ready channels.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                              Dir   Content
//   -------   ----------------------------------   ---   --------------------
//   input     in_valid_i, in_ready_o               in    command_i, operand_i
//   output    out_valid_o, out_ready_i             out   result_o
//
// Cycles: one item per cycle sustained while out_ready_i is high; an accepted
// item passes through the input register, one conversion stage and the result
// register before it is valid at the output.
// The single combinational conversion stage sits between the two registers.
// Reset: clears both stage valid flags; payload registers are not reset.
// Stalls: when the result register holds an item that is not taken, the
// input stage holds, and in_ready_o drops only if that stage is also full.
// ----------------------------------------------------------------------------
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o
);

  // Input stage
  logic        s1_valid_q, s1_valid_d;
  hsfc_cmd_e   s1_cmd_q;
  logic [31:0] s1_operand_q;

  // Result stage
  logic        out_valid_q, out_valid_d;
  logic [31:0] result_q;

  logic        out_load;
  logic        in_take;
  logic [31:0] conv_result;

  // Load the result register whenever it is empty or being drained.
  assign out_load   = !out_valid_q || out_ready_i;
  // Accept while the input stage is empty or moving forward this cycle.
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the operand and command of an accepted item.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q     <= hsfc_cmd_e'(command_i);
      s1_operand_q <= operand_i;
    end
  end

  hsfc_convert u_convert (
    .cmd_i     (s1_cmd_q),
    .operand_i (s1_operand_q),
    .result_o  (conv_result)
  );

  // Advance the converted item into the result register.
  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      result_q <= conv_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A full input stage moves into a free result register on the next edge.
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_load |=> out_valid_q)
    else $error("converted item did not reach the result register");

  // A new item lands in a full input stage only when that stage empties.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && s1_valid_q |-> out_load)
    else $error("input stage overwritten while holding an item");

  // Narrowed results keep the upper half clear.
  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_cmd_q == CMD_TO_HALF |-> conv_result[31:16] == 16'h0)
    else $error("binary16 result has nonzero upper bits");

endmodule
